### design/amra_pkg.sv
// ----------------------------------------------------------------------------
// amra_pkg
// Shared constants, types and codes of the audio mix ring accumulator.
// ----------------------------------------------------------------------------
package amra_pkg;

    // ring geometry (SEG_DEPTH is a power of two)
    localparam int SEG_DEPTH = 4096;
    localparam int SEGMENTS  = 3;
    localparam int SEG_BITS  = $clog2(SEG_DEPTH);
    localparam int SEG_W     = $clog2(SEGMENTS);
    localparam int MEM_DEPTH = SEGMENTS * SEG_DEPTH;
    localparam int MEM_AW    = $clog2(MEM_DEPTH);

    // field widths
    localparam int IDX_W    = 32;
    localparam int SAMPLE_W = 24;
    localparam int GAIN_W   = 16;
    localparam int LEN_W    = 24;
    localparam int ACC_W    = 32;
    localparam int CNT_W    = 32;

    // Q1.15 gains: 1.0 is 1 << GAIN_FRAC
    localparam int GAIN_FRAC = 15;
    localparam logic [GAIN_W-1:0] GAIN_ONE      = GAIN_W'(1 << GAIN_FRAC);
    localparam logic [GAIN_W-1:0] VOLUME_RESET  = GAIN_ONE;

    localparam int AG_W    = 2 * GAIN_W;              // amplitude * fade gain
    localparam int MPROD_W = SAMPLE_W + AG_W - 1;     // |sample| * ag, < 2^54
    localparam int RPROD_W = ACC_W + GAIN_W;          // |slot| * volume
    localparam int MIX_SH  = 2 * GAIN_FRAC;           // Q1.15 * Q1.15

    typedef logic [IDX_W-1:0]           index_t;
    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic [GAIN_W-1:0]          gain_t;
    typedef logic [LEN_W-1:0]           len_t;
    typedef logic [MEM_AW-1:0]          addr_t;

    typedef enum logic {
        ACT_MIX  = 1'b0,
        ACT_READ = 1'b1
    } action_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PLACE,
        ST_DIV,
        ST_MUL_GAIN,
        ST_MUL_SAMPLE,
        ST_MIX_WB,
        ST_RD_FETCH,
        ST_RD_MUL,
        ST_RD_WB
    } state_t;

    // request to the fade-gain divider
    typedef struct packed {
        logic start;
        len_t num;
        len_t den;
    } div_req_t;

    // divider status back to the controller
    typedef struct packed {
        logic                   done;
        logic [GAIN_FRAC-1:0]   quo;
    } div_rsp_t;

endpackage

### design/amra_if.sv
// ----------------------------------------------------------------------------
// amra channel interfaces
// Item, result and volume-write channels, each with valid/ready.
// ----------------------------------------------------------------------------
interface amra_item_if;
    logic               valid;
    logic               ready;
    logic               action;
    amra_pkg::index_t   sample_index;
    amra_pkg::sample_t  sample_in;
    amra_pkg::gain_t    amplitude;
    amra_pkg::len_t     note_remaining;
    amra_pkg::len_t     release_len;

    modport source (output valid, action, sample_index, sample_in, amplitude,
                    note_remaining, release_len, input ready);
    modport sink   (input valid, action, sample_index, sample_in, amplitude,
                    note_remaining, release_len, output ready);
endinterface

interface amra_result_if;
    logic               valid;
    logic               ready;
    amra_pkg::sample_t  sample_out;
    logic               dropped;
    logic               rotated;

    modport source (output valid, sample_out, dropped, rotated, input ready);
    modport sink   (input valid, sample_out, dropped, rotated, output ready);
endinterface

interface amra_cfg_if;
    logic               valid;
    logic               ready;
    amra_pkg::gain_t    data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

### design/amra_ram.sv
// ----------------------------------------------------------------------------
// amra_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module amra_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### design/amra_div.sv
// ----------------------------------------------------------------------------
// amra_div
// Restoring divider for the release fade: quo = floor(num * 2^15 / den),
// one quotient bit per cycle, for num < den.
// ----------------------------------------------------------------------------
module amra_div (
    input  logic               clk,
    input  logic               rst_n,
    input  amra_pkg::div_req_t req,
    output amra_pkg::div_rsp_t rsp
);
    import amra_pkg::*;

    localparam int DIV_CW = $clog2(GAIN_FRAC);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CW-1:0]    cnt_reg, cnt_next;
    logic [LEN_W:0]       part_reg, part_next;
    logic [GAIN_FRAC-1:0] quo_reg, quo_next;
    len_t                 den_reg, den_next;
    logic [LEN_W:0]       shifted;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        part_next = part_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        // remainder stays below den, so it fits LEN_W bits before the shift
        shifted   = {part_reg[LEN_W-1:0], 1'b0};
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = DIV_CW'(GAIN_FRAC - 1);
            part_next = {1'b0, req.num};
            quo_next  = '0;
            den_next  = req.den;
        end
        else if (busy_reg)
        begin
            if (shifted >= {1'b0, den_reg})
            begin
                part_next = shifted - {1'b0, den_reg};
                quo_next  = {quo_reg[GAIN_FRAC-2:0], 1'b1};
            end
            else
            begin
                part_next = shifted;
                quo_next  = {quo_reg[GAIN_FRAC-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        part_reg <= part_next;
        quo_reg  <= quo_next;
        den_reg  <= den_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;

endmodule

### design/audio_mix_ring_accumulator_top.sv
// ----------------------------------------------------------------------------
// audio_mix_ring_accumulator_top
// Three-segment ring of 32-bit mix accumulators in one synchronous RAM.
// ----------------------------------------------------------------------------
// Usage:
//  item   : one word per operation. action 0 mixes sample_in * amplitude *
//           fade into the slot of sample_index; action 1 reads and clears the
//           next head slot. Items are taken one at a time.
//  result : one word per item: sample_out (reads), dropped (mix past the
//           third segment), rotated (read that finished a segment).
//  cfg    : volume write, always ready; write it only while idle.
//  A mix inside the release fade also runs the 15-step gain divider; a
//  dropped or late mix skips the multiplies and the RAM access.
//  Each read or placed mix is a read-modify-write of one RAM entry, one access a cycle.
//  After reset a clearing pass writes zero to all 12288 entries, one per
//  cycle; no item is taken until it ends. Volume resets to 1.0.
//  The result sits in an output register; a stalled receiver holds the
//  result and the next item's write-back waits, item acceptance continues
//  up to that point.
// ----------------------------------------------------------------------------
module audio_mix_ring_accumulator_top (
    input  logic          clk,
    input  logic          rst_n,
    amra_item_if.sink     item,
    amra_result_if.source result,
    amra_cfg_if.sink      cfg
);
    import amra_pkg::*;

    state_t               state_reg, state_next;
    addr_t                clr_reg, clr_next;
    logic [SEG_BITS-1:0]  offset_reg, offset_next;
    logic [SEG_W-1:0]     head_reg, head_next;
    logic [CNT_W-1:0]     retired_reg, retired_next;
    gain_t                volume_reg, volume_next;
    logic                 out_valid_reg, out_valid_next;

    // item and datapath registers (no reset)
    logic                 action_reg;
    index_t               idx_reg;
    sample_t              sample_reg;
    gain_t                amp_reg;
    len_t                 rem_reg;
    len_t                 rel_reg;
    gain_t                g_reg, g_next;
    logic [AG_W-1:0]      ag_reg, ag_next;
    logic [MPROD_W-1:0]   mprod_reg, mprod_next;
    addr_t                addr_reg, addr_next;
    logic [RPROD_W-1:0]   rprod_reg, rprod_next;
    logic                 rneg_reg, rneg_next;
    sample_t              sout_reg, sout_next;
    logic                 drop_reg, drop_next;
    logic                 rot_reg, rot_next;

    // RAM port
    logic                 ram_we, ram_re;
    addr_t                ram_waddr, ram_raddr;
    logic [ACC_W-1:0]     ram_wdata, ram_rdata;

    div_req_t             div_req;
    div_rsp_t             div_rsp;

    // placement
    logic [CNT_W-1:0]     abs_seg, seg_diff;
    logic                 seg_ge, seg_drop, seg_late;
    logic [SEG_W-1:0]     rseg;
    logic [SEG_W:0]       pseg_sum;
    logic [SEG_W-1:0]     pseg;
    logic                 fade;

    // mix arithmetic
    logic [SAMPLE_W-1:0]  smag;
    logic [SAMPLE_W:0]    add_mag;
    logic [ACC_W+1:0]     add_s, sum_s;
    logic [ACC_W-1:0]     sum_sat;

    // read arithmetic
    logic [ACC_W-1:0]     slot_mag;
    logic [RPROD_W-MIX_SH/2:0] rd_mag;
    sample_t              rd_sat;

    logic                 out_free, load_out;

    amra_ram #(
        .WIDTH (ACC_W),
        .DEPTH (MEM_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    amra_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_comb
    begin
        // placement of the mix index relative to the head segment
        abs_seg  = CNT_W'(idx_reg[IDX_W-1:SEG_BITS]);
        seg_ge   = abs_seg >= retired_reg;
        seg_diff = abs_seg - retired_reg;
        seg_drop = seg_ge && (seg_diff >= CNT_W'(SEGMENTS));
        rseg     = seg_ge ? seg_diff[SEG_W-1:0] : '0;
        seg_late = !seg_drop && (rseg == '0) && (idx_reg[SEG_BITS-1:0] < offset_reg);
        pseg_sum = {1'b0, head_reg} + {1'b0, rseg};
        pseg     = (pseg_sum >= (SEG_W+1)'(SEGMENTS)) ?
                   SEG_W'(pseg_sum - (SEG_W+1)'(SEGMENTS)) : pseg_sum[SEG_W-1:0];
        // rem == rel gives exactly 1.0, same as no fade
        fade     = (rel_reg != '0) && (rem_reg < rel_reg);

        // mix: round half away from zero, then saturating accumulate
        smag    = sample_reg[SAMPLE_W-1] ? SAMPLE_W'(-sample_reg) : SAMPLE_W'(sample_reg);
        add_mag = (SAMPLE_W+1)'(mprod_reg[MPROD_W-1:MIX_SH]) +
                  (SAMPLE_W+1)'(mprod_reg[MIX_SH-1]);
        add_s   = sample_reg[SAMPLE_W-1] ? -((ACC_W+2)'(add_mag)) : (ACC_W+2)'(add_mag);
        sum_s   = {{2{ram_rdata[ACC_W-1]}}, ram_rdata} + add_s;
        if (sum_s[ACC_W+1:ACC_W-1] == 3'b000 || sum_s[ACC_W+1:ACC_W-1] == 3'b111)
        begin
            sum_sat = sum_s[ACC_W-1:0];
        end
        else
        begin
            sum_sat = sum_s[ACC_W+1] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end

        // read: |slot| * volume, round, saturate to Q1.23
        slot_mag = ram_rdata[ACC_W-1] ? -ram_rdata : ram_rdata;
        rd_mag   = (RPROD_W-MIX_SH/2+1)'(rprod_reg[RPROD_W-1:GAIN_FRAC]) +
                   (RPROD_W-MIX_SH/2+1)'(rprod_reg[GAIN_FRAC-1]);
        if (rneg_reg)
        begin
            rd_sat = (rd_mag > (RPROD_W-MIX_SH/2+1)'(1 << (SAMPLE_W-1))) ?
                     {1'b1, {(SAMPLE_W-1){1'b0}}} : SAMPLE_W'(-rd_mag);
        end
        else
        begin
            rd_sat = (rd_mag > (RPROD_W-MIX_SH/2+1)'((1 << (SAMPLE_W-1)) - 1)) ?
                     {1'b0, {(SAMPLE_W-1){1'b1}}} : SAMPLE_W'(rd_mag);
        end
    end

    assign out_free = !out_valid_reg || result.ready;

    always_comb
    begin
        state_next   = state_reg;
        clr_next     = clr_reg;
        offset_next  = offset_reg;
        head_next    = head_reg;
        retired_next = retired_reg;
        volume_next  = volume_reg;
        g_next       = g_reg;
        ag_next      = ag_reg;
        mprod_next   = mprod_reg;
        addr_next    = addr_reg;
        rprod_next   = rprod_reg;
        rneg_next    = rneg_reg;
        sout_next    = sout_reg;
        drop_next    = drop_reg;
        rot_next     = rot_reg;
        load_out     = 1'b0;
        ram_we       = 1'b0;
        ram_waddr    = addr_reg;
        ram_wdata    = '0;
        ram_re       = 1'b0;
        ram_raddr    = addr_reg;
        div_req      = '{start: 1'b0, num: rem_reg, den: rel_reg};
        item.ready   = 1'b0;
        cfg.ready    = 1'b1;

        if (cfg.valid)
        begin
            volume_next = cfg.data;
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == addr_t'(MEM_DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                item.ready = 1'b1;
                if (item.valid)
                begin
                    state_next = (item.action == ACT_READ) ? ST_RD_FETCH : ST_PLACE;
                end
            end
            ST_PLACE:
            begin
                addr_next = {pseg, idx_reg[SEG_BITS-1:0]};
                g_next    = GAIN_ONE;
                if (seg_drop || seg_late)
                begin
                    if (out_free)
                    begin
                        load_out   = 1'b1;
                        sout_next  = '0;
                        drop_next  = seg_drop;
                        rot_next   = 1'b0;
                        state_next = ST_IDLE;
                    end
                end
                else if (fade)
                begin
                    div_req.start = 1'b1;
                    state_next    = ST_DIV;
                end
                else
                begin
                    state_next = ST_MUL_GAIN;
                end
            end
            ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    g_next     = GAIN_W'(div_rsp.quo);
                    state_next = ST_MUL_GAIN;
                end
            end
            ST_MUL_GAIN:
            begin
                ag_next    = AG_W'(amp_reg * g_reg);
                state_next = ST_MUL_SAMPLE;
            end
            ST_MUL_SAMPLE:
            begin
                mprod_next = MPROD_W'(smag * ag_reg[AG_W-2:0]);
                ram_re     = 1'b1;
                state_next = ST_MIX_WB;
            end
            ST_MIX_WB:
            begin
                // read data holds in the RAM register while the output stalls
                if (out_free)
                begin
                    ram_we     = 1'b1;
                    ram_wdata  = sum_sat;
                    load_out   = 1'b1;
                    sout_next  = '0;
                    drop_next  = 1'b0;
                    rot_next   = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            ST_RD_FETCH:
            begin
                addr_next  = {head_reg, offset_reg};
                ram_raddr  = {head_reg, offset_reg};
                ram_re     = 1'b1;
                state_next = ST_RD_MUL;
            end
            ST_RD_MUL:
            begin
                rneg_next  = ram_rdata[ACC_W-1];
                rprod_next = RPROD_W'(slot_mag * volume_reg);
                state_next = ST_RD_WB;
            end
            ST_RD_WB:
            begin
                if (out_free)
                begin
                    ram_we     = 1'b1;
                    ram_wdata  = '0;
                    load_out   = 1'b1;
                    sout_next  = rd_sat;
                    drop_next  = 1'b0;
                    rot_next   = 1'b0;
                    offset_next = offset_reg + 1'b1;
                    if (offset_reg == SEG_BITS'(SEG_DEPTH - 1))
                    begin
                        offset_next  = '0;
                        head_next    = (head_reg == SEG_W'(SEGMENTS - 1)) ? '0 : head_reg + 1'b1;
                        retired_next = retired_reg + 1'b1;
                        rot_next     = 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            offset_reg    <= '0;
            head_reg      <= '0;
            retired_reg   <= '0;
            volume_reg    <= VOLUME_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            offset_reg    <= offset_next;
            head_reg      <= head_next;
            retired_reg   <= retired_next;
            volume_reg    <= volume_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
        begin
            action_reg <= item.action;
            idx_reg    <= item.sample_index;
            sample_reg <= item.sample_in;
            amp_reg    <= item.amplitude;
            rem_reg    <= item.note_remaining;
            rel_reg    <= item.release_len;
        end
        g_reg     <= g_next;
        ag_reg    <= ag_next;
        mprod_reg <= mprod_next;
        addr_reg  <= addr_next;
        rprod_reg <= rprod_next;
        rneg_reg  <= rneg_next;
        sout_reg  <= sout_next;
        drop_reg  <= drop_next;
        rot_reg   <= rot_next;
    end

    assign result.valid      = out_valid_reg;
    assign result.sample_out = sout_reg;
    assign result.dropped    = drop_reg;
    assign result.rotated    = rot_reg;

`ifndef SYNTHESIS
    // the mix placement state is only entered for a mix item, never for a read item
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PLACE) |-> (action_reg == ACT_MIX))
        else $error("mix placement entered for a read word");

    // head segment index stays inside the ring
    assert property (@(posedge clk) disable iff (!rst_n)
        head_reg <= SEG_W'(SEGMENTS - 1))
        else $error("head segment out of range");

    // a rotation bumps the retired count and the head together
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RD_WB && out_free && offset_reg == SEG_BITS'(SEG_DEPTH - 1))
        |=> (retired_reg == $past(retired_reg) + 1'b1) && (offset_reg == '0)
            && (head_reg != $past(head_reg)))
        else $error("segment rotation incomplete");

    // dropped words carry no sample and no rotation
    assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.dropped) |-> (result.sample_out == '0) && !result.rotated)
        else $error("dropped word with payload");
`endif

endmodule
